// ===== rtl/dual_magnetometer_interference_removal_defines.svh =====
// Assertion macros shared by the RTL of the interference removal block.
// No dependencies; included by the top level.
`ifndef DUAL_MAGNETOMETER_INTERFERENCE_REMOVAL_DEFINES_SVH
`define DUAL_MAGNETOMETER_INTERFERENCE_REMOVAL_DEFINES_SVH

// same-cycle implication
`define DMIR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmir assertion failed");

// next-cycle implication
`define DMIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmir assertion failed");

`endif

// ===== rtl/dmir_pkg.sv =====
// Shared constants and types for the interference removal block.
// No dependencies.
package dmir_pkg;

  localparam int OUT_W = 26;
  localparam int STATUS_W = 2;
  localparam int CORR_W = 64;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEGEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic             ovf;
    logic [OUT_W-1:0] quot;
  } div_res_t;

endpackage

// ===== rtl/dual_magnetometer_interference_removal.sv =====
// Dual-magnetometer interference removal. A load transfer (action 0) that writes the
// store stalls the input through S_LMUL (product) and S_LACC (accumulate), so the next
// load waits until the one before is accumulated. A fetch (action 1) that reaches the
// divider steps through S_FRD, S_FMLO, S_FMHI, S_FSUM and S_FDIV, then puts its result
// in the output register from S_FOUT; the two-bit-per-cycle divider over the NW-bit
// numerator is the longest of these steps. A fetch that ends in a range or degenerate
// status goes straight to S_FOUT. Results wait in an output register, so loads are taken
// while a result is stalled. A fetch holds the input in S_FOUT until that register frees.
module dual_magnetometer_interference_removal #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  action,
  input  logic signed [SAMPLE_BITS-1:0]         sample_a,
  input  logic signed [SAMPLE_BITS-1:0]         sample_b,
  input  logic                                  last_sample,
  input  logic [$clog2(MAX_SAMPLES)-1:0]        fetch_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dmir_pkg::OUT_W-1:0]     ambient,
  output logic signed [dmir_pkg::OUT_W-1:0]     interference,
  output logic [dmir_pkg::STATUS_W-1:0]         status
);

  `include "dual_magnetometer_interference_removal_defines.svh"

  localparam int OW = dmir_pkg::OUT_W;
  localparam int CW64 = dmir_pkg::CORR_W;
  localparam int IDXW = $clog2(MAX_SAMPLES);
  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int DIFW = SAMPLE_BITS + 1;
  localparam int MW = 2 * SAMPLE_BITS + 1;
  localparam int PW = DIFW + CW64;
  localparam int NW = PW + (PW % 2);
  localparam int PPW = DIFW + 32;
  localparam int EW = ((SAMPLE_BITS > OW) ? SAMPLE_BITS : OW) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LMUL = 4'd1;
  localparam logic [3:0] S_LACC = 4'd2;
  localparam logic [3:0] S_FRD  = 4'd3;
  localparam logic [3:0] S_FMLO = 4'd4;
  localparam logic [3:0] S_FMHI = 4'd5;
  localparam logic [3:0] S_FSUM = 4'd6;
  localparam logic [3:0] S_FDIV = 4'd7;
  localparam logic [3:0] S_FOUT = 4'd8;

  logic [3:0] state;
  logic [CNTW-1:0] pair_count;
  logic [CW64-1:0] c1, c2;
  logic set_complete;

  logic signed [SAMPLE_BITS-1:0] a_r, b_r;
  logic signed [DIFW-1:0] d_r;
  logic signed [MW-1:0] prod1, prod2;
  logic [CW64-1:0] cdiff;
  logic [DIFW-1:0] md;
  logic [CW64-1:0] mc, mn;
  logic neg;
  logic [PPW-1:0] plo, phi;
  logic [NW-1:0] num;
  logic div_start, div_done;
  dmir_pkg::div_res_t div_res;
  logic signed [OW-1:0] itf;
  logic [dmir_pkg::STATUS_W-1:0] res_status;

  logic in_xfer;
  logic [CNTW-1:0] cnt_eff;
  logic store_we;
  logic signed [DIFW-1:0] d_in;
  logic [SAMPLE_BITS-1:0] ram_a;
  logic [DIFW-1:0] ram_d;
  logic signed [DIFW-1:0] ram_d_s;
  logic signed [EW-1:0] amb_full;
  logic signed [OW-1:0] amb_sat;
  logic [OW-1:0] q;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cnt_eff  = set_complete ? '0 : pair_count;
  assign store_we = in_xfer && !action && (cnt_eff < CNTW'(MAX_SAMPLES));
  assign d_in     = DIFW'(sample_b) - DIFW'(sample_a);
  assign ram_d_s  = ram_d;
  assign q        = div_res.quot;
  assign num      = NW'(plo) + (NW'(phi) << 32);

  dmir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_inner (
    .clk(clk), .we(store_we), .waddr(cnt_eff[IDXW-1:0]), .wdata(sample_a),
    .raddr(fetch_index), .rdata(ram_a)
  );

  dmir_ram #(.WIDTH(DIFW), .DEPTH(MAX_SAMPLES)) u_diff (
    .clk(clk), .we(store_we), .waddr(cnt_eff[IDXW-1:0]), .wdata(d_in),
    .raddr(fetch_index), .rdata(ram_d)
  );

  dmir_div #(.NW(NW), .DW(CW64)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(mn),
    .done(div_done), .res(div_res)
  );

  assign div_start = (state == S_FSUM);

  always_comb begin
    amb_full = EW'(a_r) - EW'(itf);
    if (amb_full > EW'(signed'({1'b0, {(OW-1){1'b1}}}))) begin
      amb_sat = {1'b0, {(OW-1){1'b1}}};
    end else if (amb_full < -EW'(signed'({1'b0, 1'b1, {(OW-1){1'b0}}}))) begin
      amb_sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      amb_sat = amb_full[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pair_count   <= '0;
      c1           <= '0;
      c2           <= '0;
      set_complete <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_FOUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && !action) begin
            set_complete <= last_sample;
            if (set_complete) begin
              c1 <= '0;
              c2 <= '0;
            end
            pair_count <= store_we ? cnt_eff + 1'b1 : cnt_eff;
            if (store_we) begin
              state <= S_LMUL;
            end
          end else if (in_xfer) begin
            if (!set_complete || CNTW'(fetch_index) >= pair_count || c1 == c2) begin
              state <= S_FOUT;
            end else begin
              state <= S_FRD;
            end
          end
        end
        S_LMUL: state <= S_LACC;
        S_LACC: begin
          c1    <= c1 + CW64'(prod1);
          c2    <= c2 + CW64'(prod2);
          state <= S_IDLE;
        end
        S_FRD:  state <= S_FMLO;
        S_FMLO: state <= S_FMHI;
        S_FMHI: state <= S_FSUM;
        S_FSUM: state <= S_FDIV;
        S_FDIV: begin
          if (div_done) begin
            state <= S_FOUT;
          end
        end
        S_FOUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        a_r   <= action ? '0 : sample_a;
        b_r   <= sample_b;
        d_r   <= d_in;
        cdiff <= c1 - c2;
        itf   <= '0;
        if (!set_complete || CNTW'(fetch_index) >= pair_count) begin
          res_status <= dmir_pkg::ST_RANGE;
        end else if (c1 == c2) begin
          res_status <= dmir_pkg::ST_DEGEN;
        end else begin
          res_status <= dmir_pkg::ST_OK;
        end
      end
      S_LMUL: begin
        prod1 <= MW'(a_r) * MW'(d_r);
        prod2 <= MW'(b_r) * MW'(d_r);
      end
      S_FRD: begin
        a_r <= ram_a;
        md  <= ram_d_s[DIFW-1] ? DIFW'(-ram_d_s) : ram_d;
        mc  <= c2[CW64-1] ? -c2 : c2;
        mn  <= cdiff[CW64-1] ? -cdiff : cdiff;
        neg <= ram_d_s[DIFW-1] ^ c2[CW64-1] ^ cdiff[CW64-1];
      end
      S_FMLO: plo <= PPW'(md) * PPW'(mc[31:0]);
      S_FMHI: phi <= PPW'(md) * PPW'(mc[CW64-1:32]);
      S_FDIV: begin
        if (div_done) begin
          if (neg) begin
            if (div_res.ovf || (q[OW-1] && (|q[OW-2:0]))) begin
              itf <= {1'b1, {(OW-1){1'b0}}};
            end else begin
              itf <= -signed'(q);
            end
          end else begin
            if (div_res.ovf || q[OW-1]) begin
              itf <= {1'b0, {(OW-1){1'b1}}};
            end else begin
              itf <= signed'(q);
            end
          end
        end
      end
      S_FOUT: begin
        if (!out_valid || !out_stall) begin
          ambient      <= amb_sat;
          interference <= itf;
          status       <= res_status;
        end
      end
      default: ;
    endcase
  end

  `DMIR_ASSERT_NOW(a_flag_zero, out_valid && status != dmir_pkg::ST_OK,
                   ambient == '0 && interference == '0)
  `DMIR_ASSERT_NEXT(a_fetch_busy, in_valid && !in_stall && action, in_stall)
  `DMIR_ASSERT_NOW(a_count_max, 1'b1, pair_count <= CNTW'(MAX_SAMPLES))
  `DMIR_ASSERT_NEXT(a_div_out, div_done, state == S_FOUT)

endmodule

// ===== rtl/dmir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dmir_div.sv =====
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Keeps the low quotient bits and a sticky flag for any higher bit. Uses dmir_pkg.
module dmir_div #(
  parameter int NW = 90,
  parameter int DW = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NW-1:0]     num,
  input  logic [DW-1:0]     den,
  output logic              done,
  output dmir_pkg::div_res_t res
);

  localparam int QW = dmir_pkg::OUT_W;
  localparam int STEPS = NW / 2;
  localparam int CNTW = $clog2(STEPS + 1);

  logic [DW-1:0]   rem;
  logic [NW-1:0]   num_sh;
  logic [DW-1:0]   den_r;
  logic [QW-1:0]   quot;
  logic            ovf;
  logic            busy;
  logic [CNTW-1:0] cnt;

  logic [DW:0]   r1, r2;
  logic [DW+1:0] d1, d2;
  logic          ge1, ge2;
  logic [DW-1:0] rem1, rem2;

  always_comb begin
    r1   = {rem, num_sh[NW-1]};
    d1   = {1'b0, r1} - {2'b00, den_r};
    ge1  = !d1[DW+1];
    rem1 = ge1 ? d1[DW-1:0] : r1[DW-1:0];
    r2   = {rem1, num_sh[NW-2]};
    d2   = {1'b0, r2} - {2'b00, den_r};
    ge2  = !d2[DW+1];
    rem2 = ge2 ? d2[DW-1:0] : r2[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
      den_r  <= den;
      quot   <= '0;
      ovf    <= 1'b0;
    end else if (busy) begin
      rem    <= rem2;
      num_sh <= {num_sh[NW-3:0], 2'b00};
      quot   <= {quot[QW-3:0], ge1, ge2};
      ovf    <= ovf | quot[QW-1] | quot[QW-2];
    end
  end

  assign res.quot = quot;
  assign res.ovf  = ovf;

endmodule

// ===== tb/tb_dual_magnetometer_interference_removal.sv =====
// Self-checking testbench for dual_magnetometer_interference_removal: sample-pair sets
// are loaded, fetches are checked against an in-bench gradiometer predictor.
// Depends on dmir_pkg and the RTL top level.
module tb_dual_magnetometer_interference_removal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;
  localparam int DEPTH = 1024;
  localparam longint SAT_HI = (64'sd1 <<< (dmir_pkg::OUT_W - 1)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (dmir_pkg::OUT_W - 1));
  localparam int WATCHDOG = 4000;

  typedef struct {
    logic        act;
    logic [23:0] a;
    logic [23:0] b;
    logic        last;
    logic [9:0]  idx;
    bit          drain;
  } pair_item_t;

  typedef struct {
    logic signed [dmir_pkg::OUT_W-1:0] amb;
    logic signed [dmir_pkg::OUT_W-1:0] itf;
    logic [dmir_pkg::STATUS_W-1:0]     st;
  } field_result_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, action = 0, last_sample = 0;
  logic signed [23:0] sample_a = 0, sample_b = 0;
  logic [9:0] fetch_index = 0;
  logic out_valid, out_stall = 0;
  logic signed [dmir_pkg::OUT_W-1:0] ambient, interference;
  logic [dmir_pkg::STATUS_W-1:0] status;

  dual_magnetometer_interference_removal uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  pair_item_t pending[$];
  field_result_t expected_fields[$];
  int errors = 0;
  bit tail = 0;

  // predictor state
  logic signed [23:0] inner_mem[DEPTH];
  logic signed [24:0] diff_mem[DEPTH];
  int unsigned loaded = 0;
  logic [63:0] corr_inner = 0, corr_outer = 0;
  bit set_done = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic enqueue(input pair_item_t t);
    pending.insert(pending.size(), t);
  endtask

  task automatic absorb_pair(input logic signed [23:0] a, input logic signed [23:0] b,
                             input logic last);
    longint sa, sb, d;
    sa = a;
    sb = b;
    d = sb - sa;
    if (set_done) begin
      loaded = 0;
      corr_inner = 0;
      corr_outer = 0;
      set_done = 0;
    end
    if (loaded < DEPTH) begin
      inner_mem[loaded] = a;
      diff_mem[loaded] = d[24:0];
      corr_inner += sa * d;
      corr_outer += sb * d;
      loaded++;
    end
    if (last) set_done = 1;
  endtask

  function automatic field_result_t fetch_fields(input logic [9:0] i);
    field_result_t r;
    longint dl, itf, amb;
    logic [63:0] dn, md, mc, mn;
    logic [127:0] q;
    bit neg;
    r.amb = 0;
    r.itf = 0;
    if (!set_done || i >= loaded) begin
      r.st = dmir_pkg::ST_RANGE;
      return r;
    end
    if (corr_inner == corr_outer) begin
      r.st = dmir_pkg::ST_DEGEN;
      return r;
    end
    dl = diff_mem[i];
    dn = corr_inner - corr_outer;
    md = dl < 0 ? -dl : dl;
    mc = corr_outer[63] ? -corr_outer : corr_outer;
    mn = dn[63] ? -dn : dn;
    neg = (dl < 0) ^ corr_outer[63] ^ dn[63];
    q = ({64'b0, md} * {64'b0, mc}) / {64'b0, mn};
    if (neg) itf = (q > 128'(-SAT_LO)) ? SAT_LO : -longint'(q[63:0]);
    else itf = (q > 128'(SAT_HI)) ? SAT_HI : longint'(q[63:0]);
    amb = longint'(inner_mem[i]) - itf;
    if (amb > SAT_HI) amb = SAT_HI;
    if (amb < SAT_LO) amb = SAT_LO;
    r.amb = amb[dmir_pkg::OUT_W-1:0];
    r.itf = itf[dmir_pkg::OUT_W-1:0];
    r.st = dmir_pkg::ST_OK;
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 0;
      end else if (!tail && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 12);
        in_valid <= 0;
      end else if (pending.size() != 0 &&
                   !(pending[0].drain && (expected_fields.size() != 0 || in_valid))) begin
        in_valid <= 1;
        action <= pending[0].act;
        sample_a <= pending[0].a;
        sample_b <= pending[0].b;
        last_sample <= pending[0].last;
        fetch_index <= pending[0].idx;
        pending[0].drain = 0;
        void'(pending.pop_front());
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1;
    end else if (!tail && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 12);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // monitor
  int idle_cycles = 0;
  always @(posedge clk) begin
    field_result_t e;
    bit moved;
    if (!rst) begin
      moved = 0;
      if (in_valid && !in_stall) begin
        moved = 1;
        if (action == ACT_LOAD) absorb_pair(sample_a, sample_b, last_sample);
        else expected_fields.insert(expected_fields.size(), fetch_fields(fetch_index));
      end
      if (out_valid && !out_stall) begin
        moved = 1;
        if (expected_fields.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          e = expected_fields.pop_front();
          if (status !== e.st) report($sformatf("status %0d, want %0d", status, e.st));
          if (ambient !== e.amb)
            report($sformatf("ambient %0d, want %0d", ambient, e.amb));
          if (interference !== e.itf)
            report($sformatf("interference %0d, want %0d", interference, e.itf));
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("** dual_magnetometer_interference_removal: FAILED **");
        $finish;
      end
    end
  end

  function automatic pair_item_t mk_load(input logic [23:0] a, input logic [23:0] b,
                                         input logic last);
    pair_item_t t;
    t.act = ACT_LOAD;
    t.a = a;
    t.b = b;
    t.last = last;
    t.idx = 10'($urandom);
    t.drain = 0;
    return t;
  endfunction

  function automatic pair_item_t mk_fetch(input logic [9:0] i);
    pair_item_t t;
    t.act = ACT_FETCH;
    t.a = 24'($urandom);
    t.b = 24'($urandom);
    t.last = 1'($urandom);
    t.idx = i;
    t.drain = 0;
    return t;
  endfunction

  initial begin
    int total, n, nf, sets;
    bit degen;
    logic [23:0] a;
    pair_item_t t;
    // directed
    enqueue(mk_fetch(0));
    enqueue(mk_load(24'h800000, 24'h7fffff, 0));
    enqueue(mk_fetch(0));
    enqueue(mk_load(24'h7fffff, 24'h800000, 0));
    enqueue(mk_load(24'h000000, 24'h000001, 0));
    enqueue(mk_load(24'hffffff, 24'h000000, 1));
    for (int i = 0; i < 5; i++) enqueue(mk_fetch(10'(i)));
    enqueue(mk_fetch(10'h3ff));
    enqueue(mk_load(24'h123456, 24'h123456, 0));
    enqueue(mk_load(24'h800000, 24'h800000, 1));
    enqueue(mk_fetch(0));
    enqueue(mk_fetch(1));
    enqueue(mk_fetch(2));
    enqueue(mk_load(24'h000010, 24'h7fffff, 1));
    enqueue(mk_fetch(0));
    // random sets, one of them overfills the store
    total = 0;
    sets = 0;
    while (total < 1000) begin
      degen = ($urandom_range(0, 19) == 0);
      n = (sets == 6) ? 1030 : $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
        a = 24'($urandom);
        t = mk_load(a, degen ? a : 24'($urandom), i == n - 1);
        if (i == 0 && $urandom_range(0, 19) == 0) t.drain = 1;
        enqueue(t);
        if ($urandom_range(0, 29) == 0) enqueue(mk_fetch(10'($urandom)));
        if ($urandom_range(0, 49) == 0) enqueue(mk_load(24'($urandom),
                                                         24'($urandom), 0));
      end
      nf = $urandom_range(1, 8);
      for (int i = 0; i < nf; i++)
        enqueue(mk_fetch($urandom_range(0, 4) == 0 ? 10'($urandom) :
                         10'($urandom_range(0, (n > DEPTH ? DEPTH : n) - 1))));
      total += n + nf;
      sets++;
    end
    pending[pending.size() / 2].drain = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    wait (pending.size() < 150);
    tail = 1;
    wait (pending.size() == 0 && !in_valid);
    wait (expected_fields.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_fields.size() == 0)
      $display("** dual_magnetometer_interference_removal: PASSED **");
    else
      $display("** dual_magnetometer_interference_removal: FAILED **");
    $finish;
  end
endmodule
